>>> design/asc_pkg.sv
// Shared constants, types and helper functions for the accelerometer sample
// conditioning block. No dependencies; used by asc_window and the top level.

package asc_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 12;
    localparam int LEVEL_W = 13;
    localparam int ACC_W   = 12;
    localparam int NUM_AX  = 3;

    // moving-average window
    localparam int WINDOW_LEN = 10;
    localparam int POS_W      = $clog2(WINDOW_LEN);
    localparam int SUM_W      = CNT_W + $clog2(WINDOW_LEN);

    // sum / WINDOW_LEN as multiply by a rounded-up reciprocal
    localparam int              AVG_SHIFT  = SUM_W + 6;
    localparam longint unsigned AVG_MULT   =
        ((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int              AVG_MULT_W = $clog2(AVG_MULT + 1);
    localparam int              AVG_PROD_W = SUM_W + AVG_MULT_W;

    // level * 981 / (10 * ONE_G) as multiply by a rounded-up reciprocal
    localparam int              ONE_G       = 256;
    localparam longint unsigned CONV_NUM    = 981;
    localparam longint unsigned CONV_DEN    = 10 * ONE_G;
    localparam int              CONV_SHIFT  = 32;
    localparam longint unsigned CONV_MULT   =
        ((CONV_NUM << CONV_SHIFT) + CONV_DEN - 1) / CONV_DEN;
    localparam int              CONV_MULT_W = $clog2(CONV_MULT + 1);
    localparam int              CONV_PROD_W = CNT_W + CONV_MULT_W;
    localparam int              CONV_Q_W    = CONV_PROD_W - CONV_SHIFT;

    // saturation limits of a converted value, by magnitude
    localparam logic [31:0] ACC_MAG_POS = 32'd2047;
    localparam logic [31:0] ACC_MAG_NEG = 32'd2048;

    // configuration register indexes
    localparam int          CFG_ADDR_W       = 3;
    localparam logic [2:0]  CFG_SENSOR_KIND  = 3'd0;
    localparam logic [2:0]  CFG_AVG_ENABLE   = 3'd1;
    localparam logic [2:0]  CFG_AXIS_ORDER   = 3'd2;
    localparam logic [2:0]  CFG_OFFSET_X     = 3'd3;
    localparam logic [2:0]  CFG_OFFSET_Y     = 3'd4;
    localparam logic [2:0]  CFG_OFFSET_Z     = 3'd5;
    localparam int          CFG_DATA_W       = 12;

    // sensor byte layouts
    localparam logic KIND_BIG_ENDIAN    = 1'b0;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // output axis orders
    localparam logic [2:0] ORDER_XYZ = 3'd0;
    localparam logic [2:0] ORDER_XZY = 3'd1;
    localparam logic [2:0] ORDER_YXZ = 3'd2;
    localparam logic [2:0] ORDER_YZX = 3'd3;
    localparam logic [2:0] ORDER_ZXY = 3'd4;
    localparam logic [2:0] ORDER_ZYX = 3'd5;

    typedef logic [NUM_AX-1:0][CNT_W-1:0] t_cnt_vec;
    typedef logic [NUM_AX-1:0][SUM_W-1:0] t_sum_vec;

    // pack a byte pair, shift right 2 arithmetically, divide by 4 toward zero
    function automatic logic [CNT_W-1:0] axis_count(input logic [BYTE_W-1:0] hi,
                                                    input logic [BYTE_W-1:0] lo);
        logic signed [15:0] w;
        logic signed [13:0] sh;
        logic signed [13:0] adj;
        w   = signed'({hi, lo});
        sh  = w[15:2];
        adj = sh + (sh[13] ? 14'sd3 : 14'sd0);
        return adj[13:2];
    endfunction

    // magnitude of a converted value; the most negative code gives 2048
    function automatic logic [ACC_W-1:0] acc_mag(input logic [ACC_W-1:0] v);
        return v[ACC_W-1] ? (~v + 1'b1) : v;
    endfunction

    // source axis for an output slot under a given axis order
    function automatic logic [1:0] perm_src(input logic [2:0] order,
                                            input logic [1:0] slot);
        logic [5:0] code;
        case (order)
            ORDER_XZY: code = {AXIS_Y, AXIS_Z, AXIS_X};
            ORDER_YXZ: code = {AXIS_Z, AXIS_X, AXIS_Y};
            ORDER_YZX: code = {AXIS_X, AXIS_Z, AXIS_Y};
            ORDER_ZXY: code = {AXIS_Y, AXIS_X, AXIS_Z};
            ORDER_ZYX: code = {AXIS_X, AXIS_Y, AXIS_Z};
            default:   code = {AXIS_Z, AXIS_Y, AXIS_X};
        endcase
        return code[{slot, 1'b0} +: 2];
    endfunction

endpackage

>>> design/asc_window.sv
// Per-axis moving-average window: sample history, running sums and write slot.
// Depends on asc_pkg for widths and window length.

module asc_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_update,
    input  asc_pkg::t_cnt_vec i_cnt,
    output asc_pkg::t_sum_vec o_sum
);

    logic [asc_pkg::CNT_W-1:0] r_win [asc_pkg::NUM_AX][asc_pkg::WINDOW_LEN];
    logic [asc_pkg::SUM_W-1:0] r_sum [asc_pkg::NUM_AX];
    logic [asc_pkg::POS_W-1:0] r_pos;
    logic [asc_pkg::POS_W-1:0] n_pos;

    // new running sum: add the incoming count, drop the oldest one
    always_comb begin
        for (int a = 0; a < asc_pkg::NUM_AX; a++) begin
            o_sum[a] = r_sum[a]
                     + asc_pkg::SUM_W'(signed'(i_cnt[a]))
                     - asc_pkg::SUM_W'(signed'(r_win[a][r_pos]));
        end
    end

    assign n_pos = (r_pos == asc_pkg::POS_W'(asc_pkg::WINDOW_LEN - 1))
                 ? '0 : r_pos + 1'b1;

    // history, sums and slot pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int a = 0; a < asc_pkg::NUM_AX; a++) begin
                r_sum[a] <= '0;
                for (int k = 0; k < asc_pkg::WINDOW_LEN; k++) begin
                    r_win[a][k] <= '0;
                end
            end
        end else if (i_update) begin
            r_pos <= n_pos;
            for (int a = 0; a < asc_pkg::NUM_AX; a++) begin
                r_sum[a]        <= o_sum[a];
                r_win[a][r_pos] <= i_cnt[a];
            end
        end
    end

endmodule

>>> design/accel_sample_conditioning_top.sv
// Accelerometer sample conditioning: top level with stream ports and config port.
// Depends on asc_pkg and asc_window.

// One sample of six raw bytes enters per transaction and one result leaves per
// sample, in order. The block takes a new sample every clock cycle unless the
// result side holds it back; each result passes in order through the input
// register, window and sum stage, averaging multiply stage, offset and conversion
// multiply stage and output register, the input register loading at the accepting
// edge. The two reciprocal multiplies are each followed by a register.
// Back-pressure on the result side fills the stages before the input side stalls.
// Configuration is written through its own channel, always ready, and should
// only change while no sample is in flight.
module accel_sample_conditioning_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // raw_byte0 [7:0], raw_byte1 .. raw_byte5 [47:40]
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,
    // level_a [12:0], level_b [25:13], level_c [38:26], accel_a [50:39],
    // accel_b [62:51], accel_c [74:63], peak_a [86:75], peak_b [98:87],
    // peak_c [110:99], zero [111]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [111:0] o_m_axis_tdata,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [asc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [asc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int NA = asc_pkg::NUM_AX;

    // configuration registers
    logic                      r_cfg_kind;
    logic                      r_cfg_avg;
    logic [2:0]                r_cfg_order;
    logic [asc_pkg::CNT_W-1:0] r_cfg_off [NA];

    // input stage
    logic                       r_in_valid;
    logic [asc_pkg::BYTE_W-1:0] r_in_byte [6];

    // window stage
    logic                      r_a_valid;
    logic                      r_a_avg;
    logic [asc_pkg::SUM_W-1:0] r_a_val [NA];

    // averaging multiply stage
    logic                           r_b_valid;
    logic                           r_b_avg;
    logic [NA-1:0]                  r_b_neg;
    logic [asc_pkg::CNT_W-1:0]      r_b_raw [NA];
    logic [asc_pkg::AVG_PROD_W-1:0] r_b_prod [NA];

    // conversion multiply stage
    logic                            r_c_valid;
    logic [NA-1:0]                   r_c_neg;
    logic [asc_pkg::LEVEL_W-1:0]     r_c_level [NA];
    logic [asc_pkg::CONV_PROD_W-1:0] r_c_prod [NA];

    // output stage and peak store
    logic                        r_out_valid;
    logic [asc_pkg::LEVEL_W-1:0] r_out_level [NA];
    logic [asc_pkg::ACC_W-1:0]   r_out_acc [NA];
    logic [asc_pkg::ACC_W-1:0]   r_peak [NA];

    logic ready_in, ready_a, ready_b, ready_c, ready_out;

    asc_pkg::t_cnt_vec cnt;
    asc_pkg::t_sum_vec win_sum;
    logic              win_update;

    logic [asc_pkg::SUM_W-1:0]       abs_val  [NA];
    logic [asc_pkg::CNT_W-1:0]       mean     [NA];
    logic [asc_pkg::LEVEL_W-1:0]     level    [NA];
    logic [asc_pkg::CNT_W-1:0]       level_mag[NA];
    logic [asc_pkg::ACC_W-1:0]       acc      [NA];
    logic [asc_pkg::LEVEL_W-1:0]     n_level  [NA];
    logic [asc_pkg::ACC_W-1:0]       n_acc    [NA];
    logic [asc_pkg::ACC_W-1:0]       n_peak   [NA];

    // ready chain, each stage frees when its successor takes the data
    assign ready_out = !r_out_valid || i_m_axis_tready;
    assign ready_c   = !r_c_valid   || ready_out;
    assign ready_b   = !r_b_valid   || ready_c;
    assign ready_a   = !r_a_valid   || ready_b;
    assign ready_in  = !r_in_valid  || ready_a;

    assign o_s_axis_tready = ready_in;
    assign o_cfg_ready     = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_kind  <= 1'b0;
            r_cfg_avg   <= 1'b0;
            r_cfg_order <= asc_pkg::ORDER_XYZ;
            for (int a = 0; a < NA; a++) begin
                r_cfg_off[a] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                asc_pkg::CFG_SENSOR_KIND: r_cfg_kind   <= i_cfg_data[0];
                asc_pkg::CFG_AVG_ENABLE:  r_cfg_avg    <= i_cfg_data[0];
                asc_pkg::CFG_AXIS_ORDER:  r_cfg_order  <= i_cfg_data[2:0];
                asc_pkg::CFG_OFFSET_X:    r_cfg_off[0] <= i_cfg_data;
                asc_pkg::CFG_OFFSET_Y:    r_cfg_off[1] <= i_cfg_data;
                asc_pkg::CFG_OFFSET_Z:    r_cfg_off[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ready_in)  r_in_valid  <= i_s_axis_tvalid;
            if (ready_a)   r_a_valid   <= r_in_valid;
            if (ready_b)   r_b_valid   <= r_a_valid;
            if (ready_c)   r_c_valid   <= r_b_valid;
            if (ready_out) r_out_valid <= r_c_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (ready_in) begin
            for (int k = 0; k < 6; k++) begin
                r_in_byte[k] <= i_s_axis_tdata[k*asc_pkg::BYTE_W +: asc_pkg::BYTE_W];
            end
        end
    end

    // byte order and axis mapping
    always_comb begin
        if (r_cfg_kind == asc_pkg::KIND_BIG_ENDIAN) begin
            cnt[0] = asc_pkg::axis_count(r_in_byte[2], r_in_byte[3]);
            cnt[1] = asc_pkg::axis_count(r_in_byte[0], r_in_byte[1]);
            cnt[2] = asc_pkg::axis_count(r_in_byte[4], r_in_byte[5]);
        end else begin
            cnt[0] = asc_pkg::axis_count(r_in_byte[3], r_in_byte[2]);
            cnt[1] = asc_pkg::axis_count(r_in_byte[1], r_in_byte[0]);
            cnt[2] = asc_pkg::axis_count(r_in_byte[5], r_in_byte[4]);
        end
    end

    assign win_update = r_in_valid && ready_a && r_cfg_avg;

    asc_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (win_update),
        .i_cnt    (cnt),
        .o_sum    (win_sum)
    );

    // window stage register: running sum or plain count
    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a_avg <= r_cfg_avg;
            for (int a = 0; a < NA; a++) begin
                r_a_val[a] <= r_cfg_avg ? win_sum[a]
                                        : asc_pkg::SUM_W'(signed'(cnt[a]));
            end
        end
    end

    // sum or count magnitude times reciprocal of the window length
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            abs_val[a] = r_a_val[a][asc_pkg::SUM_W-1] ? (~r_a_val[a] + 1'b1)
                                                      : r_a_val[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b) begin
            r_b_avg <= r_a_avg;
            for (int a = 0; a < NA; a++) begin
                r_b_neg[a]  <= r_a_val[a][asc_pkg::SUM_W-1];
                r_b_raw[a]  <= r_a_val[a][asc_pkg::CNT_W-1:0];
                r_b_prod[a] <= asc_pkg::AVG_PROD_W'(abs_val[a])
                             * asc_pkg::AVG_PROD_W'(asc_pkg::AVG_MULT);
            end
        end
    end

    // truncated mean, offset, level magnitude
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            if (r_b_avg) begin
                mean[a] = r_b_prod[a][asc_pkg::AVG_SHIFT +: asc_pkg::CNT_W];
                if (r_b_neg[a]) begin
                    mean[a] = ~mean[a] + 1'b1;
                end
            end else begin
                mean[a] = r_b_raw[a];
            end
            level[a] = asc_pkg::LEVEL_W'(signed'(mean[a]))
                     - asc_pkg::LEVEL_W'(signed'(r_cfg_off[a]));
            level_mag[a] = level[a][asc_pkg::LEVEL_W-1]
                         ? asc_pkg::CNT_W'(~level[a] + 1'b1)
                         : level[a][asc_pkg::CNT_W-1:0];
        end
    end

    // conversion multiply stage
    always_ff @(posedge i_clk) begin
        if (ready_c) begin
            for (int a = 0; a < NA; a++) begin
                r_c_neg[a]   <= level[a][asc_pkg::LEVEL_W-1];
                r_c_level[a] <= level[a];
                r_c_prod[a]  <= asc_pkg::CONV_PROD_W'(level_mag[a])
                              * asc_pkg::CONV_PROD_W'(asc_pkg::CONV_MULT);
            end
        end
    end

    // quotient, sign and saturation
    always_comb begin
        logic [31:0] q;
        for (int a = 0; a < NA; a++) begin
            q = 32'(r_c_prod[a][asc_pkg::CONV_PROD_W-1:asc_pkg::CONV_SHIFT]);
            if (r_c_neg[a]) begin
                if (q > asc_pkg::ACC_MAG_NEG) q = asc_pkg::ACC_MAG_NEG;
                acc[a] = asc_pkg::ACC_W'(~q + 1'b1);
            end else begin
                if (q > asc_pkg::ACC_MAG_POS) q = asc_pkg::ACC_MAG_POS;
                acc[a] = q[asc_pkg::ACC_W-1:0];
            end
        end
    end

    // axis permutation and peak update
    always_comb begin
        logic [1:0] src;
        for (int s = 0; s < NA; s++) begin
            src        = asc_pkg::perm_src(r_cfg_order, 2'(s));
            n_level[s] = r_c_level[src];
            n_acc[s]   = acc[src];
            n_peak[s]  = (asc_pkg::acc_mag(n_acc[s]) > asc_pkg::acc_mag(r_peak[s]))
                       ? n_acc[s] : r_peak[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NA; s++) begin
                r_peak[s] <= '0;
            end
        end else if (r_c_valid && ready_out) begin
            for (int s = 0; s < NA; s++) begin
                r_peak[s] <= n_peak[s];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (ready_out) begin
            for (int s = 0; s < NA; s++) begin
                r_out_level[s] <= n_level[s];
                r_out_acc[s]   <= n_acc[s];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0,
                              r_peak[2], r_peak[1], r_peak[0],
                              r_out_acc[2], r_out_acc[1], r_out_acc[0],
                              r_out_level[2], r_out_level[1], r_out_level[0]};

`ifndef SYNTHESIS
    // input side stalls only when every stage is full and the result is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_out_valid && !i_m_axis_tready))
        else $error("input stalled without output back-pressure");

    // peak magnitudes never shrink outside reset
    a_peak_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (asc_pkg::acc_mag(r_peak[0]) >= $past(asc_pkg::acc_mag(r_peak[0]))) &&
            (asc_pkg::acc_mag(r_peak[1]) >= $past(asc_pkg::acc_mag(r_peak[1]))) &&
            (asc_pkg::acc_mag(r_peak[2]) >= $past(asc_pkg::acc_mag(r_peak[2]))))
        else $error("peak magnitude decreased");

    // a delivered value never exceeds the peak of its slot
    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            (asc_pkg::acc_mag(r_out_acc[0]) <= asc_pkg::acc_mag(r_peak[0])) &&
            (asc_pkg::acc_mag(r_out_acc[1]) <= asc_pkg::acc_mag(r_peak[1])) &&
            (asc_pkg::acc_mag(r_out_acc[2]) <= asc_pkg::acc_mag(r_peak[2])))
        else $error("output value above stored peak");
`endif

endmodule

>>> tb/tb_accel_sample_conditioning_top.sv
// Self-checking testbench for accel_sample_conditioning_top: drives raw samples
// and configuration, predicts each result in a scoreboard class, checks in order.
// Depends on asc_pkg and the design sources.
`timescale 1ns / 1ps

module tb_accel_sample_conditioning_top;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_WAIT  = 12;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [47:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [111:0] o_m_axis_tdata;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [asc_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [asc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // idling controls for the sender and the receiver
    int src_idle_pct;
    int sink_stall_pct;
    bit hold_go;
    int hold_left;

    accel_sample_conditioning_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    typedef struct {
        int level [3];
        int accel [3];
        int peak  [3];
    } t_cond_result;

    // conditioning predictor plus the queue of results still owed
    class t_accel_scoreboard;
        bit       sensor_kind;
        bit       avg_en;
        bit [2:0] axis_order;
        int       offset [3];
        int       window [3][asc_pkg::WINDOW_LEN];
        int       sums   [3];
        int       wpos;
        int       peak   [3];
        t_cond_result expected_q [$];
        int       errors;

        function new();
            sensor_kind = 1'b0;
            avg_en      = 1'b0;
            axis_order  = asc_pkg::ORDER_XYZ;
            wpos        = 0;
            errors      = 0;
            for (int a = 0; a < 3; a++) begin
                offset[a] = 0;
                sums[a]   = 0;
                peak[a]   = 0;
                for (int k = 0; k < asc_pkg::WINDOW_LEN; k++) window[a][k] = 0;
            end
        endfunction

        function void apply_reg(logic [asc_pkg::CFG_ADDR_W-1:0] addr,
                                logic [asc_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                asc_pkg::CFG_SENSOR_KIND: sensor_kind = data[0];
                asc_pkg::CFG_AVG_ENABLE:  avg_en      = data[0];
                asc_pkg::CFG_AXIS_ORDER:  axis_order  = data[2:0];
                asc_pkg::CFG_OFFSET_X:    offset[0]   = $signed(data);
                asc_pkg::CFG_OFFSET_Y:    offset[1]   = $signed(data);
                asc_pkg::CFG_OFFSET_Z:    offset[2]   = $signed(data);
                default: ;
            endcase
        endfunction

        // 16-bit word, floor shift by 2, then divide by 4 toward zero
        function int raw_to_count(logic [7:0] hi, logic [7:0] lo);
            int w;
            w = $signed({hi, lo});
            return (w >>> 2) / 4;
        endfunction

        // tenths of m/s^2, truncated, saturated to the 12-bit range
        function int to_tenths(int lvl);
            longint q;
            q = (longint'(lvl) * 981) / (10 * asc_pkg::ONE_G);
            if (q > 2047) q = 2047;
            if (q < -2048) q = -2048;
            return int'(q);
        endfunction

        function void note_sample(logic [47:0] raw);
            logic [7:0] b [6];
            int cnt [3];
            int lvl [3];
            int acc [3];
            int src [3];
            int mag_new, mag_old;
            t_cond_result r;
            for (int i = 0; i < 6; i++) b[i] = raw[8*i +: 8];
            if (sensor_kind == asc_pkg::KIND_BIG_ENDIAN) begin
                cnt[0] = raw_to_count(b[2], b[3]);
                cnt[1] = raw_to_count(b[0], b[1]);
                cnt[2] = raw_to_count(b[4], b[5]);
            end else begin
                cnt[0] = raw_to_count(b[3], b[2]);
                cnt[1] = raw_to_count(b[1], b[0]);
                cnt[2] = raw_to_count(b[5], b[4]);
            end
            // running window, only advanced while averaging is on
            if (avg_en) begin
                for (int a = 0; a < 3; a++) begin
                    sums[a] += cnt[a] - window[a][wpos];
                    window[a][wpos] = cnt[a];
                    cnt[a] = sums[a] / asc_pkg::WINDOW_LEN;
                end
                wpos = (wpos + 1 >= asc_pkg::WINDOW_LEN) ? 0 : wpos + 1;
            end
            for (int a = 0; a < 3; a++) begin
                lvl[a] = cnt[a] - offset[a];
                acc[a] = to_tenths(lvl[a]);
            end
            // unused order codes fall back to xyz
            case (axis_order)
                asc_pkg::ORDER_XZY:
                    src = '{asc_pkg::AXIS_X, asc_pkg::AXIS_Z, asc_pkg::AXIS_Y};
                asc_pkg::ORDER_YXZ:
                    src = '{asc_pkg::AXIS_Y, asc_pkg::AXIS_X, asc_pkg::AXIS_Z};
                asc_pkg::ORDER_YZX:
                    src = '{asc_pkg::AXIS_Y, asc_pkg::AXIS_Z, asc_pkg::AXIS_X};
                asc_pkg::ORDER_ZXY:
                    src = '{asc_pkg::AXIS_Z, asc_pkg::AXIS_X, asc_pkg::AXIS_Y};
                asc_pkg::ORDER_ZYX:
                    src = '{asc_pkg::AXIS_Z, asc_pkg::AXIS_Y, asc_pkg::AXIS_X};
                default:
                    src = '{asc_pkg::AXIS_X, asc_pkg::AXIS_Y, asc_pkg::AXIS_Z};
            endcase
            // peak replaced only on a strictly larger magnitude
            for (int s = 0; s < 3; s++) begin
                mag_new = (acc[src[s]] < 0) ? -acc[src[s]] : acc[src[s]];
                mag_old = (peak[s] < 0) ? -peak[s] : peak[s];
                if (mag_new > mag_old) peak[s] = acc[src[s]];
                r.level[s] = lvl[src[s]];
                r.accel[s] = acc[src[s]];
                r.peak[s]  = peak[s];
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string what, int slot, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s slot %0d mismatch: expected %0d, got %0d",
                         $time, what, slot, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [111:0] d);
            t_cond_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, got %h", $time, d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            for (int s = 0; s < 3; s++) begin
                compare_field("level", s, e.level[s], $signed(d[13*s +: 13]));
                compare_field("accel", s, e.accel[s], $signed(d[39 + 12*s +: 12]));
                compare_field("peak",  s, e.peak[s],  $signed(d[75 + 12*s +: 12]));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void report_leftover();
            if (expected_q.size() != 0) begin
                $display("%0t: results missing: expected %0d more, got 0",
                         $time, expected_q.size());
                errors++;
            end
        endfunction
    endclass

    t_accel_scoreboard sb = new();

    // clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // transaction monitors
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.apply_reg(i_cfg_addr, i_cfg_data);
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_sample(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // offer one sample, idling at random first; leaves tvalid high
    task automatic send_sample(input logic [47:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every owed result
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [asc_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [asc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // all six registers, written with the pipeline empty
    task automatic set_config(input bit kind, input bit avg, input logic [2:0] order,
                              input logic [11:0] ox, input logic [11:0] oy,
                              input logic [11:0] oz);
        drain_results();
        cfg_write(asc_pkg::CFG_SENSOR_KIND, {11'd0, kind});
        cfg_write(asc_pkg::CFG_AVG_ENABLE,  {11'd0, avg});
        cfg_write(asc_pkg::CFG_AXIS_ORDER,  {9'd0, order});
        cfg_write(asc_pkg::CFG_OFFSET_X, ox);
        cfg_write(asc_pkg::CFG_OFFSET_Y, oy);
        cfg_write(asc_pkg::CFG_OFFSET_Z, oz);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [11:0] pick_offset();
        case ($urandom_range(5))
            0: return 12'h800;
            1: return 12'h7FF;
            2: return 12'h000;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    // mostly full-range bytes, some near zero, some at the extremes
    function automatic logic [47:0] random_sample();
        logic [47:0] d;
        int hi;
        int k;
        d = {16'($urandom), $urandom};
        k = $urandom_range(9);
        for (int p = 0; p < 3; p++) begin
            hi = sb.sensor_kind ? 2*p + 1 : 2*p;
            if (k < 3)
                d[8*hi +: 8] = $urandom_range(1) ? 8'h00 : 8'hFF;
            else if (k == 3) begin
                d[8*hi +: 8]       = $urandom_range(1) ? 8'h7F : 8'h80;
                d[8*(hi ^ 1) +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        end
        return d;
    endfunction

    task automatic run_phase(input int n, input int src_pct, input int sink_pct,
                             input bit do_hold, input bit do_pause);
        set_config(1'($urandom_range(1)), $urandom_range(3) != 0, 3'($urandom_range(7)),
                   pick_offset(), pick_offset(), pick_offset());
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (do_hold) begin
            @(posedge i_clk);
            hold_go = 1'b1;
            @(negedge i_clk);
        end
        for (int i = 0; i < n; i++) begin
            if (do_pause && i == n / 2) drain_results();
            send_sample(random_sample());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_data      = '0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_go         = 1'b0;
        hold_left       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // big-endian extremes, truncation of small negatives toward zero
        set_config(1'b0, 1'b0, asc_pkg::ORDER_XYZ, 12'h000, 12'h000, 12'h000);
        send_sample(48'h0000_0000_0000);
        send_sample(48'hFF7F_FF7F_FF7F);
        send_sample(48'h0080_0080_0080);
        send_sample(48'hFFFF_FFFF_FFFF);
        send_sample(48'hF0FF_FCFF_F3FF);
        send_sample(48'h0000_FF7F_0080);

        // little-endian, offsets at the extremes, order codes 1 to 7
        for (int o = 1; o < 8; o++) begin
            set_config(1'b1, 1'b0, 3'(o), 12'h800, 12'h7FF, 12'h800);
            send_sample(48'h7FFF_8000_7FFF);
            send_sample(48'h8000_7FFF_8000);
        end

        // averaging from a cleared window
        set_config(1'b1, 1'b1, asc_pkg::ORDER_XYZ, 12'h000, 12'h000, 12'h000);
        send_sample(48'h7FFF_7FFF_7FFF);
        send_sample(48'h7FFF_7FFF_7FFF);
        send_sample(48'h8000_8000_8000);
        send_sample(48'h1234_FEDC_0400);

        // random phases across the idling modes
        run_phase(90, 0, 0, 1'b1, 1'b0);
        run_phase(90, 59, 0, 1'b0, 1'b1);
        run_phase(90, 0, 59, 1'b0, 1'b0);
        run_phase(90, 12, 12, 1'b0, 1'b0);
        run_phase(90, 0, 0, 1'b0, 1'b0);
        run_phase(90, 59, 0, 1'b0, 1'b0);
        run_phase(90, 0, 59, 1'b1, 1'b1);
        run_phase(90, 12, 12, 1'b0, 1'b0);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
